// File: hw/rtl/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg: shared types and constants for the jtag scan sequencer
// action codes, item layouts and the nibble rotation mask
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int MAX_BITS_DEFAULT = 32;

  localparam logic [31:0] ROT_MASK = 32'h000F_FFFF;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_TICK  = 3'd1,
    ACT_SET   = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_PULSE = 3'd4
  } jss_action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        ir_select;
    logic [5:0]  bit_count;
    logic [31:0] shift_data;
    logic        nibble_rotate;
    logic        tdo_bit;
  } jss_in_t;

  typedef struct packed {
    logic        tck_active;
    logic        tms_level;
    logic        tdi_out;
    logic        scan_done;
    logic [31:0] captured_data;
  } jss_out_t;

endpackage

// File: hw/rtl/jss_stream_if.sv
// ----------------------------------------------------------------------------
// jss_stream_if: valid/ready channel
// carries one item of type T per handshake
// ----------------------------------------------------------------------------
interface jss_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/jtag_scan_sequencer.sv
// ----------------------------------------------------------------------------
// jtag_scan_sequencer: jtag tap master for ir and dr scans
// a result item is queued when its input item is taken, behind any result items still held
// throughput: one input item per cycle while input ready is high; a tdi pulse gives two
//   result items and, with the sink ready, stalls the input until the sink takes one of them
// input ready is set by the fill of the three-entry result queue
// reset: synchronous active-high rst clears the scan state, tdi hold,
//   the lead idle clock register and the result queue
// ----------------------------------------------------------------------------
module jtag_scan_sequencer #(
  parameter int MAX_BITS = jss_pkg::MAX_BITS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  jss_stream_if.sink   cfg,
  jss_stream_if.sink   req,
  jss_stream_if.source rsp
);
  import jss_pkg::*;

  // widths that follow from the payload limit
  localparam int LEN_W     = $clog2(MAX_BITS + 1);
  localparam int TOTAL_MAX = ((MAX_BITS + 6 + 7) / 8) * 8;
  localparam int IDX_W     = $clog2(TOTAL_MAX + 1);
  localparam int CW        = IDX_W + 1;
  localparam int QDEPTH    = 3;
  localparam int QCNT_W    = 2;

  // configuration register
  logic lead_idle_clock;

  // scan state
  logic                tdi_hold;
  logic                scan_busy;
  logic                scan_is_ir;
  logic [IDX_W-1:0]    clock_index;
  logic [LEN_W-1:0]    scan_length;
  logic                lead_used;
  logic                rotate_flag;
  logic [MAX_BITS-1:0] out_shift;
  logic [MAX_BITS-1:0] in_shift;

  // result queue, head in entry 0
  jss_out_t            queue [QDEPTH];
  logic [QCNT_W-1:0]   count;

  // ---- configuration port: always ready, register written on handshake ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_idle_clock <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      lead_idle_clock <= cfg.data;
    end
  end

  // ---- input acceptance ----
  // room for a pulse (two items) whenever at most one entry is held
  logic accept;
  assign req.ready = (count <= QCNT_W'(1));
  assign accept    = req.valid && req.ready;

  // ---- scan timing for the current clock index ----
  logic [CW-1:0] sel_len, head, pay_end, total, idx, lead_w;
  logic          tick_tms, tick_payload, tick_done, tick_tdi;
  logic [31:0]   cap_raw, cap_rot, tick_cap;

  always_comb begin
    lead_w  = CW'(lead_used);
    sel_len = scan_is_ir ? CW'(2) : CW'(1);
    head    = lead_w + sel_len + CW'(2);
    pay_end = head + CW'(scan_length);
    // padding to a whole number of bytes of clocks
    total   = ((pay_end + CW'(8)) >> 3) << 3;
    idx     = CW'(clock_index);

    // tap walk: select clocks, then exit1 and update around the last bit
    tick_tms = ((idx >= lead_w) && (idx < lead_w + sel_len)) ||
               ((idx + CW'(1) >= pay_end) && (idx <= pay_end));
    tick_payload = (idx >= head) && (idx < pay_end);
    tick_done    = (idx + CW'(1) >= total);
    tick_tdi     = tick_payload ? out_shift[MAX_BITS-1] : tdi_hold;

    cap_raw  = 32'(in_shift);
    cap_rot  = ((cap_raw << 16) + (cap_raw >> 4)) & ROT_MASK;
    tick_cap = rotate_flag ? cap_rot : cap_raw;
  end

  // ---- start item: clamp the length and left-align the payload ----
  logic [LEN_W-1:0]    start_len;
  logic [MAX_BITS-1:0] start_shift;

  always_comb begin
    if (req.data.bit_count == 6'd0) begin
      start_len = LEN_W'(1);
    end else if (32'(req.data.bit_count) > 32'(MAX_BITS)) begin
      start_len = LEN_W'(MAX_BITS);
    end else begin
      start_len = LEN_W'(req.data.bit_count);
    end
    start_shift = MAX_BITS'(req.data.shift_data) << (LEN_W'(MAX_BITS) - start_len);
  end

  // ---- decode of one accepted item into zero, one or two result items ----
  logic [1:0] push_n;
  jss_out_t   res0, res1;
  logic       do_start, do_tick;
  logic       tdi_hold_next;

  always_comb begin
    push_n        = 2'd0;
    res0          = '0;
    res1          = '0;
    do_start      = 1'b0;
    do_tick       = 1'b0;
    tdi_hold_next = tdi_hold;
    if (scan_busy) begin
      // only ticks move a running scan
      if (req.data.action == ACT_TICK) begin
        do_tick            = 1'b1;
        push_n             = 2'd1;
        res0.tck_active    = 1'b1;
        res0.tms_level     = tick_tms;
        res0.tdi_out       = tick_tdi;
        res0.scan_done     = tick_done;
        res0.captured_data = tick_done ? tick_cap : 32'd0;
      end
    end else begin
      unique case (req.data.action)
        ACT_START: begin
          do_start = 1'b1;
        end
        ACT_SET: begin
          tdi_hold_next = 1'b1;
          push_n        = 2'd1;
          res0.tdi_out  = 1'b1;
        end
        ACT_CLEAR: begin
          tdi_hold_next = 1'b0;
          push_n        = 2'd1;
        end
        ACT_PULSE: begin
          // high then low, done on the second item
          tdi_hold_next  = 1'b0;
          push_n         = 2'd2;
          res0.tdi_out   = 1'b1;
          res1.scan_done = 1'b1;
        end
        default: begin
          // idle ticks and unused codes give nothing
        end
      endcase
    end
  end

  // ---- scan state registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      tdi_hold    <= 1'b0;
      scan_busy   <= 1'b0;
      scan_is_ir  <= 1'b0;
      clock_index <= '0;
      scan_length <= '0;
      lead_used   <= 1'b0;
      rotate_flag <= 1'b0;
      out_shift   <= '0;
      in_shift    <= '0;
    end else if (accept) begin
      tdi_hold <= tdi_hold_next;
      if (do_start) begin
        scan_is_ir  <= req.data.ir_select;
        lead_used   <= req.data.ir_select & lead_idle_clock;
        rotate_flag <= req.data.nibble_rotate;
        scan_length <= start_len;
        out_shift   <= start_shift;
        in_shift    <= '0;
        clock_index <= '0;
        scan_busy   <= 1'b1;
      end else if (do_tick) begin
        if (tick_payload) begin
          out_shift <= out_shift << 1;
          in_shift  <= {in_shift[MAX_BITS-2:0], req.data.tdo_bit};
        end
        if (tick_done) begin
          scan_busy   <= 1'b0;
          clock_index <= '0;
        end else begin
          clock_index <= clock_index + IDX_W'(1);
        end
      end
    end
  end

  // ---- result queue: pop from the head, push behind what remains ----
  logic              pop;
  logic [QCNT_W-1:0] base;
  logic [1:0]        push_eff;

  assign pop      = rsp.valid && rsp.ready;
  assign base     = count - QCNT_W'(pop);
  assign push_eff = accept ? push_n : 2'd0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      if ((push_eff != 2'd0) && (3'(i) == 3'(base))) begin
        queue[i] <= res0;
      end else if ((push_eff == 2'd2) && (3'(i) == 3'(base) + 3'd1)) begin
        queue[i] <= res1;
      end else if (pop && (i + 1 < QDEPTH)) begin
        queue[i] <= queue[(i + 1) % QDEPTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= base + QCNT_W'(push_eff);
    end
  end

  assign rsp.valid = (count != '0);
  assign rsp.data  = queue[0];

`ifndef SYNTH
  // a running scan never walks past its padded end
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_busy |-> (idx < total))
    else $error("clock index beyond scan end");

  // an idle sequencer always restarts from clock zero
  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    !scan_busy |-> (clock_index == '0))
    else $error("clock index not cleared while idle");

  // captured data only travels with the final clock of a scan
  a_cap_only_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data.scan_done) |-> (rsp.data.captured_data == 32'd0))
    else $error("captured data outside a done item");

  // a finishing tick leaves the sequencer idle
  a_done_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && do_tick && tick_done) |=> !scan_busy)
    else $error("scan still busy after its final clock");
`endif

endmodule
